[design/png_stored_stream_encoder_macros.svh]
// Assertion macros used by the encoder module.
`ifndef PNG_STORED_STREAM_ENCODER_MACROS_SVH
`define PNG_STORED_STREAM_ENCODER_MACROS_SVH

// Checked only while out of reset.
`define PNGSE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PNGSE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pngse_pkg.sv]
`default_nettype none
package pngse_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [15:0] ADLER_MOD = 16'd65521;
	localparam logic [15:0] BLOCK_MAX = 16'd65535;

	typedef logic [4:0] pngse_state_t;

	localparam pngse_state_t S_IDLE = 5'd0;
	localparam pngse_state_t S_SIG = 5'd1;
	localparam pngse_state_t S_IHLEN = 5'd2;
	localparam pngse_state_t S_IHTYPE = 5'd3;
	localparam pngse_state_t S_IHW = 5'd4;
	localparam pngse_state_t S_IHH = 5'd5;
	localparam pngse_state_t S_IHTAIL = 5'd6;
	localparam pngse_state_t S_IHCRC = 5'd7;
	localparam pngse_state_t S_IDLEN = 5'd8;
	localparam pngse_state_t S_IDTYPE = 5'd9;
	localparam pngse_state_t S_ZHDR = 5'd10;
	localparam pngse_state_t S_BLK = 5'd11;
	localparam pngse_state_t S_FILT = 5'd12;
	localparam pngse_state_t S_DATA = 5'd13;
	localparam pngse_state_t S_ADLER = 5'd14;
	localparam pngse_state_t S_IDCRC = 5'd15;
	localparam pngse_state_t S_ENDLEN = 5'd16;
	localparam pngse_state_t S_ENDTYPE = 5'd17;
	localparam pngse_state_t S_ENDCRC = 5'd18;

	typedef enum logic [1:0] {
		TYPE_IHDR,
		TYPE_IDAT,
		TYPE_IEND
	} pngse_chunk_t;

	function automatic logic [2:0] seg_last(input pngse_state_t st);
		logic [2:0] r;
		case (st)
			S_SIG: r = 3'd7;
			S_IHTAIL, S_BLK: r = 3'd4;
			S_ZHDR: r = 3'd1;
			S_IDLE, S_FILT, S_DATA: r = 3'd0;
			default: r = 3'd3;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h89;
			3'd1: r = 8'h50;
			3'd2: r = 8'h4E;
			3'd3: r = 8'h47;
			3'd4: r = 8'h0D;
			3'd5: r = 8'h0A;
			3'd6: r = 8'h1A;
			default: r = 8'h0A;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] sel32(input logic [31:0] v, input logic [1:0] idx);
		logic [31:0] s;
		s = v >> {(2'd3 - idx), 3'b000};
		return s[7:0];
	endfunction

	function automatic logic [7:0] type_byte(input pngse_chunk_t kind, input logic [1:0] idx);
		logic [31:0] word;
		case (kind)
			TYPE_IHDR: word = 32'h49484452;
			TYPE_IDAT: word = 32'h49444154;
			default: word = 32'h49454E44;
		endcase
		return sel32(word, idx);
	endfunction

endpackage
`default_nettype wire

[design/pngse_in_if.sv]
`default_nettype none
interface pngse_in_if;
	logic valid;
	logic ready;
	logic [7:0] pixel_byte;

	modport source(output valid, output pixel_byte, input ready);
	modport sink(input valid, input pixel_byte, output ready);
endinterface
`default_nettype wire

[design/pngse_out_if.sv]
`default_nettype none
interface pngse_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic last_of_run;
	logic end_of_file;

	modport source(output valid, output out_byte, output last_of_run, output end_of_file,
		input ready);
	modport sink(input valid, input out_byte, input last_of_run, input end_of_file,
		output ready);
endinterface
`default_nettype wire

[design/pngse_cfg_if.sv]
`default_nettype none
interface pngse_cfg_if;
	import pngse_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[design/pngse_crc_byte.sv]
`default_nettype none
module pngse_crc_byte (
	input wire logic [31:0] crc_in,
	input wire logic [7:0] data,
	output logic [31:0] crc_out
);
	import pngse_pkg::*;

	always_comb begin
		logic [31:0] c;
		c = crc_in ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		crc_out = c;
	end
endmodule
`default_nettype wire

[design/pngse_adler_step.sv]
`default_nettype none
module pngse_adler_step (
	input wire logic [15:0] low_in,
	input wire logic [15:0] high_in,
	input wire logic [7:0] data,
	output logic [15:0] low_out,
	output logic [15:0] high_out
);
	import pngse_pkg::*;

	always_comb begin
		logic [16:0] lo;
		logic [16:0] hi;
		lo = {1'b0, low_in} + {9'd0, data};
		if (lo >= {1'b0, ADLER_MOD}) begin
			lo = lo - {1'b0, ADLER_MOD};
		end
		hi = {1'b0, high_in} + lo;
		if (hi >= {1'b0, ADLER_MOD}) begin
			hi = hi - {1'b0, ADLER_MOD};
		end
		low_out = lo[15:0];
		high_out = hi[15:0];
	end
endmodule
`default_nettype wire

[design/pngse_len_calc.sv]
`default_nettype none
module pngse_len_calc #(
	parameter int DIM_W = 15,
	parameter int TOT_W = 33
) (
	input wire logic clk,
	input wire logic [DIM_W-1:0] width,
	input wire logic [DIM_W-1:0] height,
	output logic [TOT_W-1:0] total,
	output logic [31:0] idat_len
);
	import pngse_pkg::*;

	localparam int W = TOT_W + 4;

	logic [TOT_W-1:0] total_s1;
	logic [31:0] idat_s2;
	logic [W-1:0] blocks_c;
	logic [W-1:0] idat_c;

	always_comb begin
		logic [W-1:0] y;
		logic [W-1:0] a;
		logic [W-1:0] s;
		logic [W-1:0] a2;
		logic [W-1:0] s2;
		y = W'(total_s1) + W'(BLOCK_MAX - 16'd1);
		a = y >> 16;
		s = a + W'(y[15:0]);
		a2 = s >> 16;
		s2 = a2 + W'(s[15:0]);
		blocks_c = a + a2 + ((s2 >= W'(BLOCK_MAX)) ? W'(1) : W'(0));
		idat_c = W'(6) + W'(total_s1) + W'(5) * blocks_c;
	end

	always_ff @(posedge clk) begin
		total_s1 <= TOT_W'(height * ({width, 2'b00} + (DIM_W + 2)'(1)));
		idat_s2 <= idat_c[31:0];
	end

	assign total = total_s1;
	assign idat_len = idat_s2;
endmodule
`default_nettype wire

[design/png_stored_stream_encoder.sv]
// Channel    Dir  Payload                                  Transfer
// cfg        in   index, data (width or height)            valid & ready, ready always high
// pixel_in   in   pixel_byte                                valid & ready
// png_out    out  out_byte, last_of_run, end_of_file        valid & ready
// One output byte leaves per cycle while png_out is not stalled and pixel bytes keep arriving.
// A pixel byte inside a row gives one output byte; a row start adds the filter byte.
// The first byte of an image brings 50 output bytes, the last adds 20, a new deflate block adds 5.
// The next pixel is taken in the cycle that emits the last byte of the current one.
// A stall on png_out holds the output register and the byte sequencer.
// Reset clears all control state and sets both dimensions to one.
`default_nettype none
`include "png_stored_stream_encoder_macros.svh"
module png_stored_stream_encoder #(
	parameter int MAX_DIMENSION = 16384
) (
	input wire logic clk,
	input wire logic arst_n,
	pngse_cfg_if.sink cfg,
	pngse_in_if.sink pixel_in,
	pngse_out_if.source png_out
);
	import pngse_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
	localparam int ROW_W = DIM_W + 2;
	localparam int TOT_W = 2 * DIM_W + 3;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] d);
		logic [31:0] v;
		v = {{(32 - CFG_DATA_W){1'b0}}, d};
		if (v == 32'd0) begin
			v = 32'd1;
		end else if (v > 32'(MAX_DIMENSION)) begin
			v = 32'(MAX_DIMENSION);
		end
		return v[DIM_W-1:0];
	endfunction

	logic [DIM_W-1:0] img_w_q, img_h_q, cur_w_q, cur_h_q;
	pngse_state_t st_q, st_n;
	logic [2:0] cnt_q, cnt_n;
	logic [31:0] crc_q, crc_n;
	logic [15:0] alow_q, alow_n, ahigh_q, ahigh_n;
	logic [ROW_W-1:0] row_q, row_n;
	logic [15:0] blk_q, blk_n;
	logic [TOT_W-1:0] rem_q, rem_n;
	logic phase_q, phase_n;
	logic fdone_q, fdone_n;
	logic [7:0] pix_q;
	logic ov_q;
	logic [7:0] ob_q;
	logic olast_q, oeof_q;

	logic [TOT_W-1:0] total;
	logic [31:0] idat_len;
	logic [31:0] crc_base, crc_next;
	logic [15:0] alow_nx, ahigh_nx;
	logic [7:0] byte_c;
	logic crc_use, adv, item_end, eof_c, accept;
	logic [DIM_W-1:0] cur_w_n, cur_h_n;

	pngse_len_calc #(.DIM_W(DIM_W), .TOT_W(TOT_W)) u_len (
		.clk(clk), .width(cur_w_q), .height(cur_h_q), .total(total), .idat_len(idat_len)
	);

	pngse_crc_byte u_crc (.crc_in(crc_base), .data(byte_c), .crc_out(crc_next));

	pngse_adler_step u_adler (
		.low_in(alow_q), .high_in(ahigh_q), .data(byte_c), .low_out(alow_nx), .high_out(ahigh_nx)
	);

	assign adv = !ov_q || png_out.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		logic [15:0] len;
		logic [15:0] nlen;
		len = (rem_q > TOT_W'(BLOCK_MAX)) ? BLOCK_MAX : rem_q[15:0];
		nlen = ~len;
		crc_base = ((st_q == S_IHTYPE || st_q == S_IDTYPE || st_q == S_ENDTYPE) && cnt_q == 3'd0)
			? CRC_INIT : crc_q;
		crc_use = 1'b0;
		case (st_q)
			S_SIG: byte_c = sig_byte(cnt_q);
			S_IHLEN: byte_c = sel32(32'd13, cnt_q[1:0]);
			S_IHTYPE: begin
				byte_c = type_byte(TYPE_IHDR, cnt_q[1:0]);
				crc_use = 1'b1;
			end
			S_IHW: begin
				byte_c = sel32(32'(cur_w_q), cnt_q[1:0]);
				crc_use = 1'b1;
			end
			S_IHH: begin
				byte_c = sel32(32'(cur_h_q), cnt_q[1:0]);
				crc_use = 1'b1;
			end
			S_IHTAIL: begin
				byte_c = (cnt_q == 3'd0) ? 8'd8 : ((cnt_q == 3'd1) ? 8'd6 : 8'd0);
				crc_use = 1'b1;
			end
			S_IHCRC, S_IDCRC, S_ENDCRC: byte_c = sel32(~crc_q, cnt_q[1:0]);
			S_IDLEN: byte_c = sel32(idat_len, cnt_q[1:0]);
			S_IDTYPE: begin
				byte_c = type_byte(TYPE_IDAT, cnt_q[1:0]);
				crc_use = 1'b1;
			end
			S_ZHDR: begin
				byte_c = (cnt_q == 3'd0) ? 8'h78 : 8'h01;
				crc_use = 1'b1;
			end
			S_BLK: begin
				case (cnt_q)
					3'd0: byte_c = (rem_q <= TOT_W'(BLOCK_MAX)) ? 8'd1 : 8'd0;
					3'd1: byte_c = len[7:0];
					3'd2: byte_c = len[15:8];
					3'd3: byte_c = nlen[7:0];
					default: byte_c = nlen[15:8];
				endcase
				crc_use = 1'b1;
			end
			S_FILT: begin
				byte_c = 8'd0;
				crc_use = 1'b1;
			end
			S_DATA: begin
				byte_c = pix_q;
				crc_use = 1'b1;
			end
			S_ADLER: begin
				byte_c = sel32({ahigh_q, alow_q}, cnt_q[1:0]);
				crc_use = 1'b1;
			end
			S_ENDTYPE: begin
				byte_c = type_byte(TYPE_IEND, cnt_q[1:0]);
				crc_use = 1'b1;
			end
			default: byte_c = 8'd0;
		endcase
	end

	always_comb begin
		logic seg_end;
		logic [TOT_W-1:0] rem_dec;
		logic [ROW_W:0] row_inc;
		st_n = st_q;
		cnt_n = cnt_q;
		crc_n = crc_q;
		alow_n = alow_q;
		ahigh_n = ahigh_q;
		row_n = row_q;
		blk_n = blk_q;
		rem_n = rem_q;
		phase_n = phase_q;
		fdone_n = fdone_q;
		cur_w_n = cur_w_q;
		cur_h_n = cur_h_q;
		item_end = 1'b0;
		eof_c = 1'b0;
		seg_end = (cnt_q == seg_last(st_q));
		rem_dec = (rem_q != '0) ? rem_q - TOT_W'(1) : rem_q;
		row_inc = {1'b0, row_q} + (ROW_W + 1)'(1);
		if (adv && st_q != S_IDLE) begin
			cnt_n = seg_end ? 3'd0 : cnt_q + 3'd1;
			if (crc_use) begin
				crc_n = crc_next;
			end
			case (st_q)
				S_SIG: begin
					cur_w_n = img_w_q;
					cur_h_n = img_h_q;
					if (seg_end) st_n = S_IHLEN;
				end
				S_IHLEN: if (seg_end) st_n = S_IHTYPE;
				S_IHTYPE: if (seg_end) st_n = S_IHW;
				S_IHW: if (seg_end) st_n = S_IHH;
				S_IHH: if (seg_end) st_n = S_IHTAIL;
				S_IHTAIL: if (seg_end) st_n = S_IHCRC;
				S_IHCRC: if (seg_end) st_n = S_IDLEN;
				S_IDLEN: if (seg_end) st_n = S_IDTYPE;
				S_IDTYPE: if (seg_end) st_n = S_ZHDR;
				S_ZHDR: begin
					alow_n = 16'd1;
					ahigh_n = 16'd0;
					rem_n = total;
					row_n = '0;
					if (seg_end) st_n = S_BLK;
				end
				S_BLK: begin
					if (seg_end) begin
						blk_n = 16'd0;
						phase_n = 1'b1;
						st_n = (row_q == '0 && !fdone_q) ? S_FILT : S_DATA;
					end
				end
				S_FILT: begin
					alow_n = alow_nx;
					ahigh_n = ahigh_nx;
					blk_n = blk_q + 16'd1;
					rem_n = rem_dec;
					fdone_n = 1'b1;
					st_n = (blk_q == BLOCK_MAX - 16'd1) ? S_BLK : S_DATA;
				end
				S_DATA: begin
					alow_n = alow_nx;
					ahigh_n = ahigh_nx;
					blk_n = blk_q + 16'd1;
					rem_n = rem_dec;
					row_n = (row_inc >= {1'b0, cur_w_q, 2'b00}) ? '0 : row_inc[ROW_W-1:0];
					if (rem_dec == '0) begin
						st_n = S_ADLER;
					end else begin
						item_end = 1'b1;
						st_n = S_IDLE;
					end
				end
				S_ADLER: if (seg_end) st_n = S_IDCRC;
				S_IDCRC: if (seg_end) st_n = S_ENDLEN;
				S_ENDLEN: if (seg_end) st_n = S_ENDTYPE;
				S_ENDTYPE: if (seg_end) st_n = S_ENDCRC;
				S_ENDCRC: begin
					if (seg_end) begin
						item_end = 1'b1;
						eof_c = 1'b1;
						st_n = S_IDLE;
						crc_n = CRC_INIT;
						alow_n = 16'd1;
						ahigh_n = 16'd0;
						row_n = '0;
						blk_n = 16'd0;
						rem_n = '0;
						phase_n = 1'b0;
					end
				end
				default: st_n = S_IDLE;
			endcase
		end
		accept = pixel_in.valid && (st_q == S_IDLE || item_end);
		if (accept) begin
			fdone_n = 1'b0;
			cnt_n = 3'd0;
			if (!phase_n) begin
				st_n = S_SIG;
			end else if (blk_n == BLOCK_MAX) begin
				st_n = S_BLK;
			end else if (row_n == '0) begin
				st_n = S_FILT;
			end else begin
				st_n = S_DATA;
			end
		end
	end

	assign pixel_in.ready = (st_q == S_IDLE) || item_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= DIM_W'(1);
			img_h_q <= DIM_W'(1);
			cur_w_q <= DIM_W'(1);
			cur_h_q <= DIM_W'(1);
			st_q <= S_IDLE;
			cnt_q <= 3'd0;
			crc_q <= CRC_INIT;
			alow_q <= 16'd1;
			ahigh_q <= 16'd0;
			row_q <= '0;
			blk_q <= 16'd0;
			rem_q <= '0;
			phase_q <= 1'b0;
			fdone_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.index == REG_WIDTH) begin
				img_w_q <= clamp_dim(cfg.data);
			end
			if (cfg.valid && cfg.index == REG_HEIGHT) begin
				img_h_q <= clamp_dim(cfg.data);
			end
			cur_w_q <= cur_w_n;
			cur_h_q <= cur_h_n;
			st_q <= st_n;
			cnt_q <= cnt_n;
			crc_q <= crc_n;
			alow_q <= alow_n;
			ahigh_q <= ahigh_n;
			row_q <= row_n;
			blk_q <= blk_n;
			rem_q <= rem_n;
			phase_q <= phase_n;
			fdone_q <= fdone_n;
			if (adv) begin
				ov_q <= (st_q != S_IDLE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= pixel_in.pixel_byte;
		end
		if (adv) begin
			ob_q <= byte_c;
			olast_q <= item_end;
			oeof_q <= eof_c;
		end
	end

	assign png_out.valid = ov_q;
	assign png_out.out_byte = ob_q;
	assign png_out.last_of_run = olast_q;
	assign png_out.end_of_file = oeof_q;

	`PNGSE_ASSERT(a_eof_is_last, (ov_q && oeof_q) |-> olast_q, "end of file without last of run")
	`PNGSE_ASSERT(a_accept_starts, accept |=> (st_q != S_IDLE), "accepted item did not start")
	`PNGSE_ASSERT_ALWAYS(a_cnt_range, arst_n |-> (cnt_q <= seg_last(st_q)), "byte counter past segment end")
	`PNGSE_ASSERT(a_eof_idle, (ov_q && png_out.ready && oeof_q) |-> !phase_q,
		"image still open after end of file")
endmodule
`default_nettype wire

[test/png_stored_stream_encoder_test.sv]
`timescale 1ns / 1ps
module png_stored_stream_encoder_test;
	import pngse_pkg::*;

	localparam logic [31:0] IHDR_TAG = 32'h49484452;
	localparam logic [31:0] IDAT_TAG = 32'h49444154;
	localparam logic [31:0] IEND_TAG = 32'h49454E44;
	localparam int DIM_MAX = 16384;
	localparam int IDLE_PCT = 19;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [7:0] data;
		logic last;
		logic eof;
	} png_byte_t;

	logic clk;
	logic arst_n;

	pngse_cfg_if cfg_bus();
	pngse_in_if pin();
	pngse_out_if pout();

	png_stored_stream_encoder #(.MAX_DIMENSION(DIM_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.pixel_in(pin),
		.png_out(pout)
	);

	logic [7:0] pending_pixels[$];
	png_byte_t expected_bytes[$];
	png_byte_t step_bytes[$];

	int reg_width;
	int reg_height;
	int img_width;
	int img_height;
	logic [31:0] crc = CRC_INIT;
	int adler_lo = 1;
	int adler_hi = 0;
	int row_pos = 0;
	int blk_pos = 0;
	longint bytes_left = 0;
	logic in_image = 1'b0;

	logic idle_on;
	logic hold_req;
	int hold_left;
	int mismatches = 0;
	logic failed = 1'b0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int clamp_dim(input logic [14:0] v);
		if (v < 1) return 1;
		if (v > DIM_MAX) return DIM_MAX;
		return int'(v);
	endfunction

	function automatic void put_raw(input logic [7:0] b);
		png_byte_t nb;
		nb = '{b, 1'b0, 1'b0};
		step_bytes = {step_bytes, nb};
	endfunction

	function automatic void put_crc(input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		crc = c;
		put_raw(b);
	endfunction

	function automatic void put32_raw(input logic [31:0] v);
		for (int k = 3; k >= 0; k--)
			put_raw(v[k*8 +: 8]);
	endfunction

	function automatic void put32_crc(input logic [31:0] v);
		for (int k = 3; k >= 0; k--)
			put_crc(v[k*8 +: 8]);
	endfunction

	function automatic void put_tag(input logic [31:0] tag);
		crc = CRC_INIT;
		put32_crc(tag);
	endfunction

	function automatic void open_block();
		logic [15:0] len;
		logic [15:0] nlen;
		len = (bytes_left > 65535) ? 16'hFFFF : bytes_left[15:0];
		nlen = ~len;
		put_crc((bytes_left <= 65535) ? 8'd1 : 8'd0);
		put_crc(len[7:0]);
		put_crc(len[15:8]);
		put_crc(nlen[7:0]);
		put_crc(nlen[15:8]);
		blk_pos = 0;
	endfunction

	function automatic void deflate_byte(input logic [7:0] b);
		if (blk_pos >= 65535)
			open_block();
		put_crc(b);
		adler_lo += b;
		if (adler_lo >= 65521) adler_lo -= 65521;
		adler_hi += adler_lo;
		if (adler_hi >= 65521) adler_hi -= 65521;
		blk_pos++;
		if (bytes_left > 0) bytes_left--;
	endfunction

	function automatic void begin_image();
		logic [7:0] sig[8];
		longint total;
		longint blocks;
		longint idat_len;
		sig = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
		img_width = reg_width;
		img_height = reg_height;
		total = longint'(img_height) * (1 + 4 * longint'(img_width));
		blocks = (total + 65534) / 65535;
		idat_len = 2 + total + 5 * blocks + 4;
		for (int i = 0; i < 8; i++)
			put_raw(sig[i]);
		put32_raw(32'd13);
		put_tag(IHDR_TAG);
		put32_crc(img_width);
		put32_crc(img_height);
		put_crc(8'd8);
		put_crc(8'd6);
		put_crc(8'd0);
		put_crc(8'd0);
		put_crc(8'd0);
		put32_raw(~crc);
		put32_raw(idat_len[31:0]);
		put_tag(IDAT_TAG);
		put_crc(8'h78);
		put_crc(8'h01);
		adler_lo = 1;
		adler_hi = 0;
		bytes_left = total;
		row_pos = 0;
		open_block();
		in_image = 1'b1;
	endfunction

	function automatic void end_image();
		put32_crc({adler_hi[15:0], adler_lo[15:0]});
		put32_raw(~crc);
		put32_raw(32'd0);
		put_tag(IEND_TAG);
		put32_raw(~crc);
		step_bytes[step_bytes.size()-1].eof = 1'b1;
		crc = CRC_INIT;
		adler_lo = 1;
		adler_hi = 0;
		row_pos = 0;
		blk_pos = 0;
		bytes_left = 0;
		in_image = 1'b0;
	endfunction

	function automatic void predict_png_bytes(input logic [7:0] pixel);
		step_bytes.delete();
		if (!in_image)
			begin_image();
		if (row_pos == 0)
			deflate_byte(8'd0);
		deflate_byte(pixel);
		row_pos++;
		if (row_pos >= 4 * img_width)
			row_pos = 0;
		if (bytes_left == 0)
			end_image();
		step_bytes[step_bytes.size()-1].last = 1'b1;
		expected_bytes = {expected_bytes, step_bytes};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin.valid <= 1'b0;
			pin.pixel_byte <= 8'd0;
		end else begin
			if (pin.valid && pin.ready) begin
				predict_png_bytes(pin.pixel_byte);
				void'(pending_pixels.pop_front());
			end
			if (pin.valid && !pin.ready) begin
				pin.valid <= 1'b1;
			end else if (pending_pixels.size() > 0 &&
				!(idle_on && $urandom_range(99) < IDLE_PCT)) begin
				pin.valid <= 1'b1;
				pin.pixel_byte <= pending_pixels[0];
			end else begin
				pin.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_req) begin
			hold_left <= 400;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		png_byte_t want;
		if (!arst_n) begin
			pout.ready <= 1'b0;
		end else begin
			if (pout.valid && pout.ready) begin
				if (expected_bytes.size() == 0) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected output byte %02h at %0t", pout.out_byte, $realtime);
				end else begin
					want = expected_bytes.pop_front();
					if (pout.out_byte !== want.data || pout.last_of_run !== want.last ||
						pout.end_of_file !== want.eof) begin
						failed = 1'b1;
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch at %0t: expected byte %02h last %b eof %b, got %02h %b %b",
								$realtime, want.data, want.last, want.eof,
								pout.out_byte, pout.last_of_run, pout.end_of_file);
					end
				end
			end
			pout.ready <= (hold_left == 0) && !(idle_on && $urandom_range(99) < IDLE_PCT);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		if (idx == REG_WIDTH)
			reg_width = clamp_dim(value);
		else if (idx == REG_HEIGHT)
			reg_height = clamp_dim(value);
	endtask

	task automatic wait_drained();
		while (pending_pixels.size() > 0 || expected_bytes.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random_image(output int count);
		count = 4 * reg_width * reg_height;
		for (int i = 0; i < count; i++)
			pending_pixels = {pending_pixels, 8'($urandom)};
	endtask

	initial begin
		int sent;
		int n;
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_WIDTH;
		cfg_bus.data = '0;
		hold_req = 1'b0;
		idle_on = 1'b1;
		reg_width = 1;
		reg_height = 1;
		sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset dimensions give a single pixel.
		pending_pixels = {pending_pixels, 8'h00, 8'hFF, 8'h55, 8'hAA};
		sent += 4;
		wait_drained();

		// Zero clamps up to one.
		write_reg(REG_WIDTH, 15'h0000);
		write_reg(REG_HEIGHT, 15'h0000);
		queue_random_image(n);
		sent += n;
		wait_drained();

		write_reg(REG_WIDTH, 15'd2);
		write_reg(REG_HEIGHT, 15'd2);
		for (int i = 0; i < 16; i++)
			pending_pixels = {pending_pixels, ((i % 2) ? 8'hFF : 8'h00)};
		sent += 16;
		wait_drained();

		// The receiver holds off while a full image is offered.
		write_reg(REG_WIDTH, 15'd5);
		write_reg(REG_HEIGHT, 15'd5);
		queue_random_image(n);
		sent += n;
		@(posedge clk);
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		wait_drained();

		while (sent < 250) begin
			if ($urandom_range(1))
				write_reg(REG_WIDTH, 15'($urandom_range(1, 4)));
			if ($urandom_range(1))
				write_reg(REG_HEIGHT, 15'($urandom_range(1, 4)));
			idle_on = !(sent > 100 && sent < 200);
			queue_random_image(n);
			sent += n;
			wait_drained();
			idle_on = 1'b1;
		end

		if (!failed && expected_bytes.size() == 0) begin
			$display("[png_stored_stream_encoder] OK");
		end else begin
			$display("[png_stored_stream_encoder] ERROR");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[png_stored_stream_encoder] ERROR");
		$finish;
	end

endmodule
